// File: rtl/hd_key_path_parser_assert.svh
// Assertion macros for the derivation path parser.
// Used by the top level only; relies on i_clk and i_rst_n in scope.
`ifndef HD_KEY_PATH_PARSER_ASSERT_SVH
`define HD_KEY_PATH_PARSER_ASSERT_SVH

// Condition must hold whenever the antecedent holds, same cycle.
`define HKP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Condition must hold in the cycle after the antecedent.
`define HKP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hkp_pkg.sv
// Shared types, constants and a helper function for the derivation path parser.
// No dependencies; used by every module of the block.
package hkp_pkg;

    localparam int MAX_LEN = 510;
    localparam int CC_W    = $clog2(MAX_LEN + 2);

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_LW    = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_BIN = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [4:0] NO_DIGIT = 5'd16;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LONG  = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd3;
    localparam logic [2:0] ST_BAD_NUM   = 3'd4;
    localparam logic [2:0] ST_BAD_SLASH = 3'd5;
    localparam logic [2:0] ST_HARDENED  = 3'd6;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [31:0] HARD_BIT = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] path_element;
        logic [2:0]  status_code;
        logic        is_final;
    } t_result;

    typedef struct packed {
        logic    elem_valid;
        t_result elem;
        logic    stat_valid;
        t_result stat;
    } t_step_out;

    typedef struct packed {
        logic [Q_LW-1:0] level;
        logic            room;
    } t_q_status;

    typedef struct packed {
        logic [1:0]  base;
        logic [1:0]  pos;
        logic [31:0] acc;
        logic        ovf;
        logic        digit_seen;
        logic        harden;
        logic [2:0]  fault;
    } t_token;

    function automatic logic [4:0] digit_value(input logic [7:0] c, input logic [1:0] base);
        logic [4:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 5'(c - 8'h41 + 8'd10);
        end
        if (base == BASE_BIN && d > 5'd1) begin
            d = NO_DIGIT;
        end
        if (base == BASE_DEC && d > 5'd9) begin
            d = NO_DIGIT;
        end
        return d;
    endfunction

endpackage

// File: rtl/hkp_step.sv
// Parser state and the per-character update: token accumulate, faults, status.
// Depends on hkp_pkg.
module hkp_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [7:0]         i_ch,
    input  logic               i_last,
    output hkp_pkg::t_step_out o_step
);

    logic [hkp_pkg::CC_W-1:0] r_count, n_count;
    logic                     r_prefix, n_prefix;
    hkp_pkg::t_token          r_tok, n_tok;
    logic [2:0]               r_first, n_first;
    logic                     r_slash_fault, n_slash_fault;
    logic                     r_prev_slash, n_prev_slash;
    logic                     r_body, n_body;

    hkp_pkg::t_token          tok_body;
    logic                     is_prefix_char, is_slash, is_body;
    logic                     is_harden_char, is_base_char;
    logic [4:0]               dig;
    logic [35:0]              prod;
    logic                     do_finish;
    logic [2:0]               fin_code;
    logic [31:0]              fin_value;
    logic [2:0]               status;

    always_comb begin
        if (r_count < hkp_pkg::CC_W'(hkp_pkg::MAX_LEN + 1)) begin
            n_count = r_count + hkp_pkg::CC_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    assign is_prefix_char = (n_count == hkp_pkg::CC_W'(1)) && (i_ch == "m" || i_ch == "M");
    assign is_slash       = !is_prefix_char && !r_prefix && (i_ch == hkp_pkg::CH_SLASH);
    assign is_body        = !is_prefix_char && !r_prefix && (i_ch != hkp_pkg::CH_SLASH);
    assign is_harden_char = (i_ch == "h" || i_ch == "H" || i_ch == hkp_pkg::CH_QUOTE);
    assign is_base_char   = (i_ch == "b" || i_ch == "B" || i_ch == "x" || i_ch == "X");

    assign dig  = hkp_pkg::digit_value(i_ch, r_tok.base);
    // scale the accumulator by the base with shifts, then add the digit
    assign prod = ((r_tok.base == hkp_pkg::BASE_BIN) ? {3'b0, r_tok.acc, 1'b0} :
                   (r_tok.base == hkp_pkg::BASE_HEX) ? {r_tok.acc, 4'b0} :
                   ({1'b0, r_tok.acc, 3'b0} + {3'b0, r_tok.acc, 1'b0}))
                  + {31'b0, dig};

    // Token update for a body character
    always_comb begin
        tok_body = r_tok;
        if (r_tok.harden) begin
            if (tok_body.fault == hkp_pkg::ST_OK) begin
                tok_body.fault = hkp_pkg::ST_BAD_CHAR;
            end
            tok_body.harden = 1'b0;
        end
        if (r_tok.pos == 2'd1 && r_tok.base == hkp_pkg::BASE_DEC && r_tok.digit_seen &&
            r_tok.acc == 32'd0 && tok_body.fault == hkp_pkg::ST_OK && is_base_char) begin
            tok_body.base       = (i_ch == "b" || i_ch == "B") ? hkp_pkg::BASE_BIN
                                                               : hkp_pkg::BASE_HEX;
            tok_body.digit_seen = 1'b0;
            tok_body.pos        = 2'd2;
        end else begin
            if (r_tok.pos != 2'd2) begin
                tok_body.pos = r_tok.pos + 2'd1;
            end
            if (is_harden_char) begin
                tok_body.harden = 1'b1;
            end else if (dig == hkp_pkg::NO_DIGIT) begin
                if (tok_body.fault == hkp_pkg::ST_OK) begin
                    tok_body.fault = hkp_pkg::ST_BAD_CHAR;
                end
            end else begin
                if (r_tok.ovf || prod[35:32] != 4'd0) begin
                    tok_body.ovf = 1'b1;
                end else begin
                    tok_body.acc = prod[31:0];
                end
                tok_body.digit_seen = 1'b1;
            end
        end
        if (!is_body) begin
            tok_body = r_tok;
        end
    end

    // A slash leaves the token untouched, so one finish per character at most
    assign do_finish = (is_slash || i_last) && (tok_body.pos != 2'd0);

    always_comb begin
        fin_code  = hkp_pkg::ST_OK;
        fin_value = 32'd0;
        if (tok_body.fault != hkp_pkg::ST_OK) begin
            fin_code = hkp_pkg::ST_BAD_CHAR;
        end else if (!tok_body.digit_seen || tok_body.ovf) begin
            fin_code = hkp_pkg::ST_BAD_NUM;
        end else if (tok_body.harden) begin
            if (tok_body.acc[31]) begin
                fin_code = hkp_pkg::ST_HARDENED;
            end else begin
                fin_value = tok_body.acc | hkp_pkg::HARD_BIT;
            end
        end else begin
            fin_value = tok_body.acc;
        end
    end

    always_comb begin
        n_prefix      = is_prefix_char;
        n_slash_fault = r_slash_fault;
        n_prev_slash  = r_prev_slash;
        n_body        = r_body;
        n_first       = r_first;
        if (is_slash) begin
            if (!r_body || r_prev_slash) begin
                n_slash_fault = 1'b1;
            end
            n_prev_slash = 1'b1;
            n_body       = 1'b1;
        end else if (is_body) begin
            n_prev_slash = 1'b0;
            n_body       = 1'b1;
        end
        if (do_finish && fin_code != hkp_pkg::ST_OK && r_first == hkp_pkg::ST_OK) begin
            n_first = fin_code;
        end
        n_tok = do_finish ? '0 : tok_body;
    end

    always_comb begin
        if (n_count > hkp_pkg::CC_W'(hkp_pkg::MAX_LEN)) begin
            status = hkp_pkg::ST_TOO_LONG;
        end else if (!n_body) begin
            status = hkp_pkg::ST_EMPTY;
        end else if (n_slash_fault || n_prev_slash) begin
            status = hkp_pkg::ST_BAD_SLASH;
        end else begin
            status = n_first;
        end
    end

    always_comb begin
        o_step.elem_valid        = i_go && do_finish;
        o_step.elem.path_element = fin_value;
        o_step.elem.status_code  = hkp_pkg::ST_OK;
        o_step.elem.is_final     = 1'b0;
        o_step.stat_valid        = i_go && i_last;
        o_step.stat.path_element = 32'd0;
        o_step.stat.status_code  = status;
        o_step.stat.is_final     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_count       <= '0;
            r_prefix      <= 1'b0;
            r_tok         <= '0;
            r_first       <= hkp_pkg::ST_OK;
            r_slash_fault <= 1'b0;
            r_prev_slash  <= 1'b0;
            r_body        <= 1'b0;
        end else if (i_go) begin
            r_count       <= n_count;
            r_prefix      <= n_prefix;
            r_tok         <= n_tok;
            r_first       <= n_first;
            r_slash_fault <= n_slash_fault;
            r_prev_slash  <= n_prev_slash;
            r_body        <= n_body;
        end
    end

endmodule

// File: rtl/hkp_out_queue.sv
// Result queue: takes up to two results a cycle, hands out one per cycle while popped.
// Depends on hkp_pkg.
module hkp_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hkp_pkg::t_step_out i_step,
    input  logic               i_pop,
    output logic               o_valid,
    output hkp_pkg::t_result   o_head,
    output hkp_pkg::t_q_status o_status
);

    hkp_pkg::t_result          r_mem [hkp_pkg::Q_DEPTH];
    logic [hkp_pkg::Q_AW-1:0]  r_wp, n_wp;
    logic [hkp_pkg::Q_AW-1:0]  r_rp;
    logic [hkp_pkg::Q_LW-1:0]  r_level, n_level;
    logic [hkp_pkg::Q_AW-1:0]  wp_second;
    logic                      pop_ok;

    assign pop_ok    = i_pop && (r_level != '0);
    assign wp_second = r_wp + hkp_pkg::Q_AW'(i_step.elem_valid);
    assign n_wp      = r_wp + hkp_pkg::Q_AW'(i_step.elem_valid) +
                       hkp_pkg::Q_AW'(i_step.stat_valid);
    assign n_level   = r_level + hkp_pkg::Q_LW'(i_step.elem_valid) +
                       hkp_pkg::Q_LW'(i_step.stat_valid) - hkp_pkg::Q_LW'(pop_ok);

    always_ff @(posedge i_clk) begin
        if (i_step.elem_valid) begin
            r_mem[r_wp] <= i_step.elem;
        end
        if (i_step.stat_valid) begin
            r_mem[wp_second] <= i_step.stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_level <= n_level;
            if (pop_ok) begin
                r_rp <= r_rp + hkp_pkg::Q_AW'(1);
            end
        end
    end

    assign o_valid         = (r_level != '0);
    assign o_head          = r_mem[r_rp];
    assign o_status.level  = r_level;
    // keep space for the two results one character can give
    assign o_status.room   = (r_level <= hkp_pkg::Q_LW'(hkp_pkg::Q_DEPTH - 2));

endmodule

// File: rtl/hd_key_path_parser.sv
// Derivation path parser top level: input register, parser step, result queue.
// An accepted character is held in the input register; its results are written to the result queue.
// Throughput: one character per cycle while the result queue has room; the final character gives up to two
// results, which leave one per cycle, while the output is ready, through a 4-entry result queue.
// Reset: synchronous, active low; clears parser state, the input register's valid bit and the queue.
// Depends on hkp_pkg, hkp_step, hkp_out_queue and hd_key_path_parser_assert.svh.
`include "hd_key_path_parser_assert.svh"

module hd_key_path_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] path_element, [34:32] status_code, zero pad
    output logic        m_axis_tlast    // is_final
);

    logic               r_in_valid;
    logic [7:0]         r_in_ch;
    logic               r_in_last;
    logic               step_go;
    hkp_pkg::t_step_out step_out;
    hkp_pkg::t_result   head;
    hkp_pkg::t_q_status q_stat;

    assign step_go       = r_in_valid && q_stat.room;
    assign s_axis_tready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    hkp_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (step_go),
        .i_ch    (r_in_ch),
        .i_last  (r_in_last),
        .o_step  (step_out)
    );

    hkp_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_out),
        .i_pop    (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_head   (head),
        .o_status (q_stat)
    );

    assign m_axis_tdata = {5'b0, head.status_code, head.path_element};
    assign m_axis_tlast = head.is_final;

    `HKP_ASSERT_SAME(a_level_bound, 1'b1, q_stat.level <= 3'(hkp_pkg::Q_DEPTH), "result queue over depth")
    `HKP_ASSERT_SAME(a_step_room, step_go, q_stat.level <= 3'(hkp_pkg::Q_DEPTH - 2), "step without queue room")
    `HKP_ASSERT_NEXT(a_level_hold, !step_go && !(m_axis_tvalid && m_axis_tready), $stable(q_stat.level), "queue level moved while idle")

endmodule
